[rtl/assert_macros.svh]
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst is low.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/met_pkg.sv]
package met_pkg;

  localparam int FRAC_BITS   = 24;
  localparam int Q_W         = 32;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int LIM_W       = 11;
  localparam int PPU_W       = 13;
  localparam int ESC_W       = 3;
  localparam int FIELD_W     = 12;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_UNIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_FIRST     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_LAST      = 3'd6;

  typedef struct packed {
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [LIM_W-1:0] iteration_count;
  } color_t;

  typedef struct packed {
    logic signed [3:0] origin_real;
    logic signed [3:0] origin_imag;
    logic [PPU_W-1:0]  pixels_per_unit;
    logic [LIM_W-1:0]  iteration_limit;
    logic [ESC_W-1:0]  escape_limit;
    logic [CFG_W-1:0]  color_first;
    logic [CFG_W-1:0]  color_last;
  } cfg_t;

  // One classified pixel: its point c and everything the iteration and
  // the gradient need. Channel 0 is red, 1 green, 2 blue.
  typedef struct packed {
    logic signed [Q_W-1:0] cre;
    logic signed [Q_W-1:0] cim;
    logic [LIM_W-1:0]      lim;
    logic [ESC_W-1:0]      esc;
    logic [2:0][7:0]       start;
    logic [2:0][7:0]       step;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/met_front.sv]
module met_front #(
  parameter int COORD_BITS     = 12,
  parameter int MAX_ITERATIONS = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  met_pkg::cfg_t   cfg,
  input  logic            pixel_valid,
  output logic            pixel_stall,
  input  met_pkg::pixel_t pixel,
  input  met_pkg::qstat_t qstat,
  output logic            push,
  output met_pkg::job_t   job
);

  localparam int W     = COORD_BITS + met_pkg::FRAC_BITS;
  localparam int CW    = $clog2(W + 1);
  localparam int REM_W = met_pkg::PPU_W;
  localparam int NL    = 5;
  localparam int SUM_W = (W + 2 > 34) ? W + 2 : 34;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh8000_0000);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  fstate_t state;
  logic [CW-1:0] cnt;
  logic [W-1:0] quo [NL];
  logic [REM_W-1:0] rem [NL];
  logic [W-1:0] quo_next [NL];
  logic [REM_W-1:0] rem_next [NL];
  logic [met_pkg::PPU_W-1:0] ppu;
  logic [met_pkg::LIM_W-1:0] lim;
  logic [met_pkg::ESC_W-1:0] esc;
  logic signed [3:0] org_re;
  logic signed [3:0] org_im;
  logic [2:0][7:0] start;
  logic [2:0] neg;

  logic [15:0] col16;
  logic [15:0] row16;
  logic [COORD_BITS-1:0] col_idx;
  logic [COORD_BITS-1:0] row_idx;
  logic [met_pkg::LIM_W-1:0] lim_in;
  logic [2:0][7:0] mag_in;
  logic [2:0] neg_in;
  logic signed [SUM_W-1:0] sum_re;
  logic signed [SUM_W-1:0] sum_im;

  assign col16   = 16'(pixel.column);
  assign row16   = 16'(pixel.row);
  assign col_idx = col16[COORD_BITS-1:0];
  assign row_idx = row16[COORD_BITS-1:0];

  always_comb begin
    lim_in = (cfg.iteration_limit == '0) ? met_pkg::LIM_W'(1) : cfg.iteration_limit;
    if (32'(lim_in) > 32'(MAX_ITERATIONS)) lim_in = met_pkg::LIM_W'(MAX_ITERATIONS);
    for (int c = 0; c < 3; c++) begin
      logic [8:0] diff;
      diff = {1'b0, cfg.color_last[(2-c)*8 +: 8]} - {1'b0, cfg.color_first[(2-c)*8 +: 8]};
      neg_in[c] = diff[8];
      mag_in[c] = diff[8] ? 8'(-diff) : diff[7:0];
    end
  end

  // One restoring step per lane: lanes 0 and 1 divide by the scale,
  // lanes 2 to 4 divide the colour spans by the limit.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic [REM_W:0] trial;
      logic [REM_W:0] dvs;
      logic ge;
      trial = {rem[l], quo[l][W-1]};
      dvs = (l < 2) ? (REM_W + 1)'(ppu) : (REM_W + 1)'(lim);
      ge = trial >= dvs;
      rem_next[l] = ge ? REM_W'(trial - dvs) : REM_W'(trial);
      quo_next[l] = {quo[l][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (pixel_valid) begin
            quo[0] <= {col_idx, met_pkg::FRAC_BITS'(0)};
            quo[1] <= {row_idx, met_pkg::FRAC_BITS'(0)};
            for (int c = 0; c < 3; c++) quo[2+c] <= W'(mag_in[c]);
            for (int l = 0; l < NL; l++) rem[l] <= '0;
            ppu <= (cfg.pixels_per_unit == '0) ? met_pkg::PPU_W'(1) : cfg.pixels_per_unit;
            lim <= lim_in;
            esc <= (cfg.escape_limit == '0) ? met_pkg::ESC_W'(1) : cfg.escape_limit;
            org_re <= cfg.origin_real;
            org_im <= cfg.origin_imag;
            for (int c = 0; c < 3; c++) start[c] <= cfg.color_first[(2-c)*8 +: 8];
            neg <= neg_in;
            cnt <= '0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          for (int l = 0; l < NL; l++) begin
            quo[l] <= quo_next[l];
            rem[l] <= rem_next[l];
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!qstat.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign pixel_stall = (state != F_IDLE);
  assign push = (state == F_PUSH) && !qstat.full;

  always_comb begin
    sum_re = (SUM_W'(org_re) <<< met_pkg::FRAC_BITS) + $signed(SUM_W'(quo[0]));
    sum_im = (SUM_W'(org_im) <<< met_pkg::FRAC_BITS) + $signed(SUM_W'(quo[1]));
    job.cre = (sum_re > SAT_MAX) ? 32'sh7FFF_FFFF :
              (sum_re < SAT_MIN) ? 32'sh8000_0000 : 32'(sum_re);
    job.cim = (sum_im > SAT_MAX) ? 32'sh7FFF_FFFF :
              (sum_im < SAT_MIN) ? 32'sh8000_0000 : 32'(sum_im);
    job.lim = lim;
    job.esc = esc;
    job.start = start;
    for (int c = 0; c < 3; c++) begin
      job.step[c] = neg[c] ? 8'(-quo[2+c][7:0]) : quo[2+c][7:0];
    end
  end

endmodule

[rtl/met_queue.sv]
module met_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  met_pkg::job_t   push_job,
  input  logic            pop,
  output met_pkg::job_t   head,
  output met_pkg::qstat_t qstat
);

  localparam int DEPTH = met_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  met_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head = slots[rd_ptr];
  assign qstat.full = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);

endmodule

[rtl/met_back.sv]
module met_back (
  input  logic            clk,
  input  logic            rst,
  input  met_pkg::qstat_t qstat,
  input  met_pkg::job_t   head,
  output logic            pop,
  output logic            color_valid,
  input  logic            color_stall,
  output met_pkg::color_t color
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_UPD, B_FIN} bstate_t;

  function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  bstate_t state;
  met_pkg::job_t cur;
  logic signed [31:0] re;
  logic signed [31:0] im;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic [met_pkg::LIM_W-1:0] k;

  logic [63:0] mag;
  logic [63:0] bound;
  logic escaped;
  logic signed [63:0] diff;
  logic signed [31:0] nre;
  logic signed [31:0] nim;
  logic [met_pkg::LIM_W-1:0] k_inc;
  logic [met_pkg::LIM_W-1:0] k_m1;
  logic [2:0][7:0] chan;
  logic out_free;
  logic fin_fire;

  always_comb begin
    mag = 64'(rr) + 64'(ii);
    bound = 64'(cur.esc) << (2 * met_pkg::FRAC_BITS);
    escaped = mag >= bound;
    diff = rr - ii;
    nre = sat_q((diff >>> met_pkg::FRAC_BITS) + 64'(cur.cre));
    nim = sat_q((ri >>> (met_pkg::FRAC_BITS - 1)) + 64'(cur.cim));
    k_inc = k + 1'b1;
    k_m1 = k - 1'b1;
    for (int c = 0; c < 3; c++) begin
      logic [15:0] prod;
      prod = k_m1[7:0] * cur.step[c];
      chan[c] = cur.start[c] + prod[7:0];
    end
  end

  assign pop = (state == B_IDLE) && !qstat.empty;
  assign out_free = !color_valid || !color_stall;
  assign fin_fire = (state == B_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      color_valid <= 1'b0;
    end else begin
      if (fin_fire) color_valid <= 1'b1;
      else if (color_valid && !color_stall) color_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            cur <= head;
            re <= '0;
            im <= '0;
            k <= '0;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          rr <= re * re;
          ii <= im * im;
          ri <= re * im;
          state <= B_UPD;
        end
        B_UPD: begin
          if (escaped) begin
            state <= B_FIN;
          end else if (nre == re && nim == im) begin
            // fixed point: the pixel never escapes
            k <= cur.lim;
            state <= B_FIN;
          end else begin
            re <= nre;
            im <= nim;
            k <= k_inc;
            state <= (k_inc == cur.lim) ? B_FIN : B_MUL;
          end
        end
        B_FIN: begin
          if (out_free) begin
            if (k == cur.lim) begin
              color.red <= '0;
              color.green <= '0;
              color.blue <= '0;
            end else begin
              color.red <= chan[0];
              color.green <= chan[1];
              color.blue <= chan[2];
            end
            color.iteration_count <= k;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/mandelbrot_escape_time_pixel.sv]
// Escape-time colouring of one Mandelbrot pixel per beat. A front end maps
// column and row to c in Q8.24 with a bit-serial divider: it accepts the
// pixel, runs the divide, hands the job to the queue once the queue is not
// full, and holds pixel_stall high until it is idle again. The back end runs
// the z*z + c loop with each iteration in B_MUL (the three 32x32 products)
// and then B_UPD (the escape test and update); B_IDLE takes the job and
// B_FIN presents the result. With the queue the two halves overlap, and
// the sustained rate is the slower of the two, set by the back end's loop
// for all but quickly escaping points.
// Configuration writes take effect for pixels accepted afterwards.
`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
  parameter int MAX_ITERATIONS = 1024,
  parameter int COORD_BITS     = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [met_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [met_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              pixel_valid,
  output logic                              pixel_stall,
  input  met_pkg::pixel_t                   pixel,
  output logic                              color_valid,
  input  logic                              color_stall,
  output met_pkg::color_t                   color
);

  met_pkg::cfg_t cfg;
  met_pkg::qstat_t qstat;
  met_pkg::job_t push_job;
  met_pkg::job_t head;
  logic push;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real <= -4'sd2;
      cfg.origin_imag <= -4'sd1;
      cfg.pixels_per_unit <= 13'd1000;
      cfg.iteration_limit <= 11'd100;
      cfg.escape_limit <= 3'd2;
      cfg.color_first <= 24'hFF3200;
      cfg.color_last <= 24'h0000FF;
    end else if (cfg_we) begin
      case (cfg_index)
        met_pkg::CFG_ORIGIN_REAL:     cfg.origin_real <= cfg_data[3:0];
        met_pkg::CFG_ORIGIN_IMAG:     cfg.origin_imag <= cfg_data[3:0];
        met_pkg::CFG_PIXELS_PER_UNIT: cfg.pixels_per_unit <= cfg_data[12:0];
        met_pkg::CFG_ITERATION_LIMIT: cfg.iteration_limit <= cfg_data[10:0];
        met_pkg::CFG_ESCAPE_LIMIT:    cfg.escape_limit <= cfg_data[2:0];
        met_pkg::CFG_COLOR_FIRST:     cfg.color_first <= cfg_data;
        met_pkg::CFG_COLOR_LAST:      cfg.color_last <= cfg_data;
        default: ;
      endcase
    end
  end

  met_front #(
    .COORD_BITS(COORD_BITS),
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .qstat(qstat),
    .push(push),
    .job(push_job)
  );

  met_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_job(push_job),
    .pop(pop),
    .head(head),
    .qstat(qstat)
  );

  met_back u_back (
    .clk(clk),
    .rst(rst),
    .qstat(qstat),
    .head(head),
    .pop(pop),
    .color_valid(color_valid),
    .color_stall(color_stall),
    .color(color)
  );

  `ASSERT_CLK(a_no_overflow, clk, rst, push |-> !qstat.full)
  `ASSERT_CLK(a_no_underflow, clk, rst, pop |-> !qstat.empty)
  `ASSERT_CLK(a_count_nonzero, clk, rst, color_valid |-> color.iteration_count != '0)
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (pixel_valid && !pixel_stall) |=> pixel_stall)

endmodule
